### rtl/bshs_pkg.sv
// ----------------------------------------------------------------------------
// bshs_pkg
// Shared types, constants and helpers for the border-safe heading selector.
// ----------------------------------------------------------------------------
package bshs_pkg;

  localparam int POS_W    = 14;  // position fields, signed
  localparam int DES_W    = 10;  // desired heading, signed
  localparam int HEAD_W   = 9;   // wrapped heading -179..180, signed
  localparam int KIND_W   = 2;
  localparam int DIM_W    = 12;  // field extents
  localparam int MARGIN_W = 10;
  localparam int LOOK_W   = 10;
  localparam int WRAP_W   = 11;  // headroom for heading sums before wrapping
  localparam int FOLD_W   = 10;  // degree value fed to the quarter-wave fold
  localparam int ERR_W    = 8;   // angular error magnitude 0..180
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FIELD_LENGTH = 2'd1;
  localparam logic [1:0] REG_MARGIN       = 2'd2;
  localparam logic [1:0] REG_LOOKAHEAD    = 2'd3;

  localparam logic [DIM_W-1:0]    RST_FIELD_WIDTH  = 12'd2928;
  localparam logic [DIM_W-1:0]    RST_FIELD_LENGTH = 12'd3888;
  localparam logic [MARGIN_W-1:0] RST_MARGIN       = 10'd80;
  localparam logic [LOOK_W-1:0]   RST_LOOKAHEAD    = 10'd240;

  typedef enum logic [KIND_W-1:0] {
    KIND_DESIRED = 2'd0,
    KIND_TANGENT = 2'd1,
    KIND_STEPPED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DIM_W-1:0]    field_width;
    logic [DIM_W-1:0]    field_length;
    logic [MARGIN_W-1:0] safety_margin;
    logic [LOOK_W-1:0]   lookahead_distance;
  } cfg_t;

  // request / response between sequencer and the exit check unit
  typedef struct packed {
    logic                     start;
    logic signed [HEAD_W-1:0] heading;
  } chk_req_t;

  typedef struct packed {
    logic done;
    logic exits;
  } chk_rsp_t;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } fold_t;

  // Q1.14 sine, whole degrees 0..90
  localparam logic [14:0] SINE_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Reduce to -179..180. Valid for inputs -539..539.
  function automatic logic signed [HEAD_W-1:0] wrap_deg(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] r;
    r = a + 11'sd179;
    if (r < 0) begin
      r = r + 11'sd360;
    end else if (r >= 11'sd360) begin
      r = r - 11'sd360;
    end
    return HEAD_W'(r - 11'sd179);
  endfunction

  // Fold a degree value (-359..359) onto the 0..90 table with a sign.
  function automatic fold_t sin_fold(input logic signed [FOLD_W-1:0] deg);
    logic signed [FOLD_W-1:0] d;
    fold_t f;
    d = deg;
    f.neg = 1'b0;
    if (d < 0) begin
      d = d + 10'sd360;
    end
    if (d >= 10'sd180) begin
      d = d - 10'sd180;
      f.neg = 1'b1;
    end
    if (d > 10'sd90) begin
      d = 10'sd180 - d;
    end
    f.idx = 7'(d);
    return f;
  endfunction

endpackage

### rtl/bshs_if.sv
// ----------------------------------------------------------------------------
// bshs_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bshs_in_if import bshs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [DES_W-1:0]  desired_heading;

  modport source (output valid, output pos_x, output pos_y, output desired_heading,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input desired_heading,
                  output ready);
endinterface

interface bshs_out_if import bshs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] safe_heading;
  logic [KIND_W-1:0]        choice_kind;

  modport source (output valid, output safe_heading, output choice_kind, input ready);
  modport sink   (input valid, input safe_heading, input choice_kind, output ready);
endinterface

### rtl/bshs_exit_chk.sv
// ----------------------------------------------------------------------------
// bshs_exit_chk
// Lookahead exit test for one heading: one shared table lookup and multiplier,
// x axis then y axis.
// ----------------------------------------------------------------------------
module bshs_exit_chk import bshs_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  chk_req_t                req,
  output chk_rsp_t                rsp
);

  localparam int B      = TRIG_FRACTION_BITS;
  localparam int TRIG_W = B + 2;
  localparam int PROD_W = TRIG_W + LOOK_W + 1;
  localparam int SUM_W  = B + 16;
  localparam int RSH    = (B < 14) ? (14 - B) : 0;
  localparam int RND    = (B < 14) ? (1 << (13 - B)) : 0;
  localparam int LSH    = (B > 14) ? (B - 14) : 0;

  typedef enum logic [1:0] {PH_IDLE, PH_X, PH_Y} ph_t;

  ph_t                      ph_r;
  logic signed [HEAD_W-1:0] head_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     xbad_r;

  logic signed [FOLD_W-1:0] deg_sel;
  fold_t                    fold;
  logic [31:0]              tm;
  logic [B:0]               mag;
  logic signed [TRIG_W-1:0] trig;
  logic signed [PROD_W-1:0] prod_nxt;

  logic signed [POS_W-1:0]  pos_sel;
  logic [DIM_W-1:0]         dim_sel;
  logic signed [DIM_W+1:0]  hi_raw;
  logic signed [SUM_W-1:0]  pt;
  logic signed [SUM_W-1:0]  lo;
  logic signed [SUM_W-1:0]  hi;
  logic                     bad;

  // sine of the heading on start, cosine (heading + 90) in the x phase
  always_comb begin
    if (ph_r == PH_X) begin
      deg_sel = {head_r[HEAD_W-1], head_r} + 10'sd90;
    end else begin
      deg_sel = {req.heading[HEAD_W-1], req.heading};
    end
    fold = sin_fold(deg_sel);
    tm   = ((32'(SINE_Q14[fold.idx]) + 32'(RND)) >> RSH) << LSH;
    mag  = tm[B:0];
    trig = fold.neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    prod_nxt = PROD_W'(trig) * PROD_W'(signed'({1'b0, cfg.lookahead_distance}));
  end

  // bounds test of the point along the axis of the current phase
  always_comb begin
    pos_sel = (ph_r == PH_X) ? pos_x : pos_y;
    dim_sel = (ph_r == PH_X) ? cfg.field_width : cfg.field_length;
    hi_raw  = signed'({2'b00, dim_sel}) - signed'({4'b0000, cfg.safety_margin});
    pt  = (SUM_W'(pos_sel) <<< B) + SUM_W'(prod_r);
    lo  = SUM_W'(signed'({1'b0, cfg.safety_margin})) <<< B;
    hi  = SUM_W'(hi_raw) <<< B;
    bad = (pt < lo) || (pt > hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      unique case (ph_r)
        PH_IDLE, PH_Y: begin
          if (req.start) begin
            head_r <= req.heading;
            prod_r <= prod_nxt;
            ph_r   <= PH_X;
          end else begin
            ph_r   <= PH_IDLE;
          end
        end
        PH_X: begin
          xbad_r <= bad;
          prod_r <= prod_nxt;
          ph_r   <= PH_Y;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done  = (ph_r == PH_Y);
  assign rsp.exits = xbad_r | bad;

endmodule

### rtl/border_safe_heading_select_unit.sv
// ----------------------------------------------------------------------------
// border_safe_heading_select_unit
// Picks a heading that keeps the lookahead point inside the field margin.
// ----------------------------------------------------------------------------
// Tests: k heading tests per item (1 desired + 2 or 4 tangents + up to
//   2*MAX_FALLBACK_STEP steps), run one at a time in the shared
//   table/multiplier unit.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous active low; configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module border_safe_heading_select_unit import bshs_pkg::*; #(
  parameter int MAX_FALLBACK_STEP  = 180,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  bshs_in_if.sink           in_if,
  bshs_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int STEP_W = $clog2(MAX_FALLBACK_STEP + 1);

  localparam logic signed [HEAD_W-1:0] HEAD_N = 9'sd0;
  localparam logic signed [HEAD_W-1:0] HEAD_S = 9'sd180;
  localparam logic signed [HEAD_W-1:0] HEAD_E = 9'sd90;
  localparam logic signed [HEAD_W-1:0] HEAD_W_ = -9'sd90;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;
  typedef enum logic [1:0] {M_WANT, M_TAN, M_STEP} mode_t;

  // ---------------- configuration registers ----------------
  cfg_t cfg_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_width        <= RST_FIELD_WIDTH;
      cfg_r.field_length       <= RST_FIELD_LENGTH;
      cfg_r.safety_margin      <= RST_MARGIN;
      cfg_r.lookahead_distance <= RST_LOOKAHEAD;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FIELD_WIDTH:  cfg_r.field_width        <= pwdata[DIM_W-1:0];
        REG_FIELD_LENGTH: cfg_r.field_length       <= pwdata[DIM_W-1:0];
        REG_MARGIN:       cfg_r.safety_margin      <= pwdata[MARGIN_W-1:0];
        REG_LOOKAHEAD:    cfg_r.lookahead_distance <= pwdata[LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIELD_WIDTH:  prdata = APB_DW'(cfg_r.field_width);
      REG_FIELD_LENGTH: prdata = APB_DW'(cfg_r.field_length);
      REG_MARGIN:       prdata = APB_DW'(cfg_r.safety_margin);
      REG_LOOKAHEAD:    prdata = APB_DW'(cfg_r.lookahead_distance);
      default:          prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  state_t                   state_r;
  mode_t                    mode_r;
  logic signed [POS_W-1:0]  x_r;
  logic signed [POS_W-1:0]  y_r;
  logic signed [HEAD_W-1:0] want_r;
  logic signed [HEAD_W-1:0] head_r;
  logic                     side_r;
  logic                     endw_r;
  logic [1:0]               idx_r;
  logic                     found_r;
  logic [ERR_W-1:0]         best_err_r;
  logic signed [HEAD_W-1:0] best_r;
  logic [STEP_W-1:0]        step_r;
  logic                     neg_r;
  logic signed [HEAD_W-1:0] res_r;
  kind_t                    kind_r;
  logic                     out_valid_r;
  logic signed [HEAD_W-1:0] out_head_r;
  kind_t                    out_kind_r;

  chk_req_t req;
  chk_rsp_t rsp;

  bshs_exit_chk #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .pos_x (x_r),
    .pos_y (y_r),
    .req   (req),
    .rsp   (rsp)
  );

  assign req.start   = (state_r == S_ISSUE);
  assign req.heading = head_r;

  // walls within the margin, else the nearest wall
  logic signed [15:0] m16, x16, y16, dl, dr, db, dt, dmin;
  logic [1:0]         which;
  logic               side_c, end_c;

  always_comb begin
    m16 = signed'(16'(cfg_r.safety_margin));
    x16 = 16'(x_r);
    y16 = 16'(y_r);
    dl  = x16 - m16;
    dr  = signed'(16'(cfg_r.field_width)) - m16 - x16;
    db  = y16 - m16;
    dt  = signed'(16'(cfg_r.field_length)) - m16 - y16;
    side_c = (dl <= 0) || (dr <= 0);
    end_c  = (db <= 0) || (dt <= 0);
    dmin  = dl;
    which = 2'd0;
    if (dr < dmin) begin
      dmin  = dr;
      which = 2'd1;
    end
    if (db < dmin) begin
      dmin  = db;
      which = 2'd2;
    end
    if (dt < dmin) begin
      which = 2'd3;
    end
    if (!side_c && !end_c) begin
      side_c = (which < 2'd2);
      end_c  = !side_c;
    end
  end

  // tangent list: 0, 180 for a side wall, then 90, -90 for an end wall
  function automatic logic signed [HEAD_W-1:0] tan_angle(input logic [1:0] k,
                                                          input logic sd);
    logic [1:0] kk;
    kk = sd ? k : {1'b1, k[0]};
    case (kk)
      2'd0:    return HEAD_N;
      2'd1:    return HEAD_S;
      2'd2:    return HEAD_E;
      default: return HEAD_W_;
    endcase
  endfunction

  logic signed [WRAP_W-1:0] want_ext, step_ext;
  logic signed [HEAD_W-1:0] want_in, err_w, head_plus, head_minus, head_next_plus;
  logic [ERR_W-1:0]         err_abs;
  logic                     better, found_now, tan_last;
  logic signed [HEAD_W-1:0] best_now;

  always_comb begin
    want_in   = wrap_deg({in_if.desired_heading[DES_W-1], in_if.desired_heading});
    want_ext  = WRAP_W'(want_r);
    step_ext  = signed'(WRAP_W'(step_r));
    head_minus     = wrap_deg(want_ext - step_ext);
    head_next_plus = wrap_deg(want_ext + step_ext + 11'sd1);
    head_plus      = wrap_deg(want_ext + 11'sd1);
    err_w     = wrap_deg(WRAP_W'(head_r) - want_ext);
    err_abs   = (err_w < 0) ? ERR_W'(-err_w) : ERR_W'(err_w);
    better    = !rsp.exits && (!found_r || (err_abs < best_err_r));
    found_now = found_r || !rsp.exits;
    best_now  = better ? head_r : best_r;
    tan_last  = (side_r && endw_r) ? (idx_r == 2'd3) : (idx_r == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid_r && out_if.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            x_r     <= in_if.pos_x;
            y_r     <= in_if.pos_y;
            want_r  <= want_in;
            head_r  <= want_in;
            mode_r  <= M_WANT;
            found_r <= 1'b0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (mode_r == M_WANT) begin
            side_r <= side_c;
            endw_r <= end_c;
          end
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp.done) begin
            unique case (mode_r)
              M_WANT: begin
                if (!rsp.exits) begin
                  res_r   <= want_r;
                  kind_r  <= KIND_DESIRED;
                  state_r <= S_OUT;
                end else begin
                  mode_r  <= M_TAN;
                  idx_r   <= 2'd0;
                  head_r  <= tan_angle(2'd0, side_r);
                  state_r <= S_ISSUE;
                end
              end
              M_TAN: begin
                found_r <= found_now;
                if (better) begin
                  best_err_r <= err_abs;
                end
                best_r <= best_now;
                if (!tan_last) begin
                  idx_r   <= idx_r + 2'd1;
                  head_r  <= tan_angle(idx_r + 2'd1, side_r);
                  state_r <= S_ISSUE;
                end else if (found_now) begin
                  res_r   <= best_now;
                  kind_r  <= KIND_TANGENT;
                  state_r <= S_OUT;
                end else begin
                  mode_r  <= M_STEP;
                  step_r  <= STEP_W'(1);
                  neg_r   <= 1'b0;
                  head_r  <= head_plus;
                  state_r <= S_ISSUE;
                end
              end
              M_STEP: begin
                if (!rsp.exits) begin
                  res_r   <= head_r;
                  kind_r  <= KIND_STEPPED;
                  state_r <= S_OUT;
                end else if (!neg_r) begin
                  neg_r   <= 1'b1;
                  head_r  <= head_minus;
                  state_r <= S_ISSUE;
                end else if (step_r == STEP_W'(MAX_FALLBACK_STEP)) begin
                  res_r   <= want_r;
                  kind_r  <= KIND_NONE;
                  state_r <= S_OUT;
                end else begin
                  neg_r   <= 1'b0;
                  step_r  <= step_r + STEP_W'(1);
                  head_r  <= head_next_plus;
                  state_r <= S_ISSUE;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || out_if.ready) begin
            out_head_r  <= res_r;
            out_kind_r  <= kind_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.safe_heading = out_head_r;
  assign out_if.choice_kind  = out_kind_r;

endmodule

### tb/sv/border_safe_heading_select_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// border_safe_heading_select_unit_tb
// Drives position/heading items through several field and margin settings,
// predicts the chosen heading and its kind per item, and checks every result
// in order. Both channels idle at random; the result side also holds off once
// for a long stretch so the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module border_safe_heading_select_unit_tb import bshs_pkg::*; ();

  localparam int STEP_MAX    = 180;
  localparam int TRIG_BITS   = 14;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int DRAIN_WAIT  = 1200;   // worst heading search plus margin
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT     = 150;

  localparam longint DEF_FIELD_WIDTH  = 2928;
  localparam longint DEF_FIELD_LENGTH = 3888;
  localparam longint DEF_MARGIN       = 80;
  localparam longint DEF_LOOKAHEAD    = 240;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [DES_W-1:0] heading;
  } nav_req_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    kind_t                    kind;
  } heading_pick_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bshs_in_if  in_ch ();
  bshs_out_if out_ch ();

  border_safe_heading_select_unit #(
    .MAX_FALLBACK_STEP (STEP_MAX),
    .TRIG_FRACTION_BITS(TRIG_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Q1.14 sine by whole degree, 0..90
  int sine_tab [0:90] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // register mirror
  longint fld_w = DEF_FIELD_WIDTH;
  longint fld_l = DEF_FIELD_LENGTH;
  longint margin = DEF_MARGIN;
  longint look = DEF_LOOKAHEAD;

  nav_req_t      pending_reqs [$];
  heading_pick_t expected_picks [$];

  int  err_count;
  int  items_in;
  int  picks_checked;
  int  settings_used;
  int  kind_seen [4];
  int  cycle_cnt;
  bit  in_taken;
  int  tx_gap;
  int  tx_calm;
  int  rx_stall;
  int  rx_calm;
  int  hold_left;
  bit  held_once;

  // --------------------------------------------------------------------------
  // Heading prediction
  // --------------------------------------------------------------------------
  function automatic int wrap_heading(int a);
    int r;
    r = (a + 179) % 360;
    if (r < 0) begin
      r += 360;
    end
    return r - 179;
  endfunction

  function automatic longint trig_at(int deg);
    int     d;
    bit     neg;
    longint t;
    d = ((deg % 360) + 360) % 360;
    neg = 1'b0;
    if (d >= 180) begin
      d -= 180;
      neg = 1'b1;
    end
    if (d > 90) begin
      d = 180 - d;
    end
    t = sine_tab[d];
    if (TRIG_BITS < 14) begin
      t = (t + (longint'(1) << (13 - TRIG_BITS))) >>> (14 - TRIG_BITS);
    end else begin
      t = t * (longint'(1) << (TRIG_BITS - 14));
    end
    return neg ? -t : t;
  endfunction

  function automatic bit leaves_field(longint x, longint y, int h);
    longint one;
    longint xn;
    longint yn;
    one = longint'(1) << TRIG_BITS;
    xn = x * one + trig_at(h) * look;
    yn = y * one + trig_at(h + 90) * look;
    return xn < margin * one || xn > (fld_w - margin) * one ||
           yn < margin * one || yn > (fld_l - margin) * one;
  endfunction

  function automatic heading_pick_t pick_heading(longint x, longint y, int desired);
    int            want;
    int            cand [4];
    int            n;
    int            i;
    int            a;
    int            e;
    int            best_err;
    int            step;
    int            which;
    bit            side;
    bit            ends;
    bit            found;
    longint        dmin;
    heading_pick_t p;
    want = wrap_heading(desired);
    p.heading = HEAD_W'(want);
    p.kind = KIND_NONE;
    if (!leaves_field(x, y, want)) begin
      p.kind = KIND_DESIRED;
      return p;
    end
    side = (x <= margin) || (x >= fld_w - margin);
    ends = (y <= margin) || (y >= fld_l - margin);
    if (!side && !ends) begin
      // nearest wall: left, right, bottom, top; strict less replaces
      dmin = x - margin;
      which = 0;
      if ((fld_w - margin) - x < dmin) begin
        dmin = (fld_w - margin) - x;
        which = 1;
      end
      if (y - margin < dmin) begin
        dmin = y - margin;
        which = 2;
      end
      if ((fld_l - margin) - y < dmin) begin
        which = 3;
      end
      side = which < 2;
      ends = !side;
    end
    n = 0;
    if (side) begin
      cand[0] = 0;
      cand[1] = 180;
      n = 2;
    end
    if (ends) begin
      cand[n] = 90;
      cand[n+1] = -90;
      n += 2;
    end
    found = 1'b0;
    best_err = 0;
    for (i = 0; i < n; i++) begin
      a = wrap_heading(cand[i]);
      if (!leaves_field(x, y, a)) begin
        e = wrap_heading(a - want);
        if (e < 0) begin
          e = -e;
        end
        if (!found || e < best_err) begin
          found = 1'b1;
          best_err = e;
          p.heading = HEAD_W'(a);
        end
      end
    end
    if (found) begin
      p.kind = KIND_TANGENT;
      return p;
    end
    for (step = 1; step <= STEP_MAX; step++) begin
      a = wrap_heading(want + step);
      if (!leaves_field(x, y, a)) begin
        p.heading = HEAD_W'(a);
        p.kind = KIND_STEPPED;
        return p;
      end
      a = wrap_heading(want - step);
      if (!leaves_field(x, y, a)) begin
        p.heading = HEAD_W'(a);
        p.kind = KIND_STEPPED;
        return p;
      end
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int clamp_pos(int v);
    if (v < -4096) begin
      return -4096;
    end
    if (v > 8191) begin
      return 8191;
    end
    return v;
  endfunction

  // mostly no gap, some short, a few long; occasional runs with none at all
  function automatic int idle_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 120);
  endfunction

  task automatic add_req(int x, int y, int h);
    nav_req_t r;
    r.x = POS_W'(x);
    r.y = POS_W'(y);
    r.heading = DES_W'(h);
    pending_reqs.push_back(r);
  endtask

  // inside the field, hugging a wall, or anywhere in the position range
  task automatic add_random(int count);
    int k;
    int r;
    int x;
    int y;
    int band;
    int off;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      x = $urandom_range(0, int'(fld_w));
      y = $urandom_range(0, int'(fld_l));
      if (r >= 85) begin
        x = int'($urandom_range(0, 12287)) - 4096;
        y = int'($urandom_range(0, 12287)) - 4096;
      end else if (r >= 55) begin
        band = int'(margin + look) + 16;
        off = int'($urandom_range(0, band)) - 8;
        case ($urandom_range(0, 3))
          0: begin
            x = off;
          end
          1: begin
            x = int'(fld_w) - off;
          end
          2: begin
            y = off;
          end
          default: begin
            y = int'(fld_l) - off;
          end
        endcase
      end
      add_req(clamp_pos(x), clamp_pos(y), int'($urandom_range(0, 720)) - 360);
    end
  endtask

  function automatic logic [APB_DW-1:0] reg_mask(logic [1:0] idx);
    if (idx == REG_FIELD_WIDTH || idx == REG_FIELD_LENGTH) begin
      return (APB_DW'(1) << DIM_W) - 1;
    end
    return (APB_DW'(1) << MARGIN_W) - 1;
  endfunction

  function automatic longint mirror_of(logic [1:0] idx);
    case (idx)
      REG_FIELD_WIDTH:  return fld_w;
      REG_FIELD_LENGTH: return fld_l;
      REG_MARGIN:       return margin;
      default:          return look;
    endcase
  endfunction

  task automatic reg_write(logic [1:0] idx, int unsigned val);
    logic [APB_DW-1:0] data;
    data = ($urandom & ~reg_mask(idx)) | (val & reg_mask(idx));
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FIELD_WIDTH:  fld_w = data & reg_mask(idx);
      REG_FIELD_LENGTH: fld_l = data & reg_mask(idx);
      REG_MARGIN:       margin = data & reg_mask(idx);
      default:          look = data & reg_mask(idx);
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(logic [1:0] idx);
    logic [APB_DW-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== APB_DW'(mirror_of(idx))) begin
      $error("register %0d: expected %0d, got %0d", idx, mirror_of(idx), got);
      err_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_field(int unsigned w, int unsigned l, int unsigned m, int unsigned la);
    reg_write(REG_FIELD_WIDTH, w);
    reg_write(REG_FIELD_LENGTH, l);
    reg_write(REG_MARGIN, m);
    reg_write(REG_LOOKAHEAD, la);
    reg_check(REG_FIELD_WIDTH);
    reg_check(REG_FIELD_LENGTH);
    reg_check(REG_MARGIN);
    reg_check(REG_LOOKAHEAD);
    settings_used++;
  endtask

  // sampled at the rising edge, where the sender's last update has settled
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_picks.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Clock, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one item per handshake from the pending queue
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    nav_req_t r;
    if (rst_n && !(in_ch.valid && !in_taken)) begin
      if (tx_gap > 0) begin
        in_ch.valid <= 1'b0;
        tx_gap--;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= r.x;
        in_ch.pos_y <= r.y;
        in_ch.desired_heading <= r.heading;
        tx_gap = idle_gap(tx_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the unit up
  always @(negedge clk) begin : receiver
    if (!held_once && items_in >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (rx_stall > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      rx_stall = idle_gap(rx_calm);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accept, compare each result with the oldest pick
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    heading_pick_t e;
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n && in_taken) begin
      expected_picks.push_back(pick_heading(longint'(in_ch.pos_x), longint'(in_ch.pos_y),
                                            int'(in_ch.desired_heading)));
      items_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: safe_heading %0d choice_kind %0d",
               out_ch.safe_heading, out_ch.choice_kind);
        err_count++;
      end else begin
        e = expected_picks.pop_front();
        kind_seen[e.kind]++;
        picks_checked++;
        if (out_ch.safe_heading !== e.heading) begin
          $error("safe_heading: expected %0d, got %0d", e.heading, out_ch.safe_heading);
          err_count++;
        end
        if (out_ch.choice_kind !== e.kind) begin
          $error("choice_kind: expected %0d, got %0d", e.kind, out_ch.choice_kind);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of field settings
  // --------------------------------------------------------------------------
  initial begin : main
    int p;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.desired_heading = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values
    reg_check(REG_FIELD_WIDTH);
    reg_check(REG_FIELD_LENGTH);
    reg_check(REG_MARGIN);
    reg_check(REG_LOOKAHEAD);
    settings_used = 1;

    add_req(1464, 1944, 0);        // open field, desired safe
    add_req(1464, 3800, 0);        // near top wall
    add_req(2900, 1944, 90);       // near right wall
    add_req(100, 100, -135);       // corner, equal error to 0 and 90; wall tie picks side, so only 0, 180 tried
    add_req(1464, 1944, 360);      // wrap cases
    add_req(1464, 1944, -360);
    add_req(1464, 1944, 270);
    add_req(1464, 1944, -270);
    add_req(1464, 1944, -180);
    add_req(1464, 1944, 180);
    add_req(1464, 1944, -179);
    add_req(1464, 60, 180);        // below margin, tangents fail, steps find one
    add_req(100, 1944, -90);       // heading into the left wall
    add_req(-4096, -4096, 45);     // far outside, nothing safe
    add_req(8191, 8191, -45);
    add_req(-4096, 8191, 359);
    add_req(8191, -4096, -1);
    add_req(2928, 3888, 135);
    add_req(0, 0, 45);
    add_random(560);
    wait_idle();

    // largest extents, margin and lookahead
    set_field(4095, 4095, 1023, 1023);
    add_random(200);
    wait_idle();

    // all zero: only the origin is safe
    set_field(0, 0, 0, 0);
    add_req(0, 0, 0);
    add_req(0, 0, 90);
    add_req(1, 0, 0);
    add_random(25);
    wait_idle();

    // margin larger than the field
    set_field(100, 200, 300, 50);
    add_random(25);
    wait_idle();

    // square field, nearest wall ties, steps needed from the center
    set_field(1000, 1000, 50, 600);
    add_req(500, 500, 0);
    add_req(500, 500, 90);
    add_req(500, 500, -135);
    add_req(500, 500, 180);
    add_req(300, 700, 0);
    add_req(700, 300, -90);
    add_random(250);
    wait_idle();

    for (p = 0; p < 4; p++) begin
      set_field($urandom_range(200, 4095), $urandom_range(200, 4095),
                $urandom_range(0, 300), $urandom_range(0, 1023));
      add_random(110);
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d results over %0d field settings, incl. a %0d-cycle receiver hold-off.",
             picks_checked, settings_used, HOLD_CYCLES);
    $display("Kinds seen: desired %0d, tangent %0d, stepped %0d, none safe %0d.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
